@@ src/pms_pkg.sv @@
// Shared types, codes and constants of the partitioned multi-stack.
package pms_pkg;

  // Default geometry.
  localparam int PMS_DEPTH      = 64;
  localparam int PMS_STACKS     = 3;
  localparam int PMS_DATA_WIDTH = 32;

  // Field and port widths.
  localparam int SIZE_W  = 7;
  localparam int RES_W   = 32;
  localparam int NUM_CFG = 3;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  // Entries of the queue between classifier and memory side (power of two).
  localparam int QDEPTH = 2;

  // Register indexes.
  localparam logic [1:0] REG_FIRST_SIZE  = 2'd0;
  localparam logic [1:0] REG_SECOND_SIZE = 2'd1;
  localparam logic [1:0] REG_THIRD_SIZE  = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET [NUM_CFG] = '{7'd20, 7'd15, 7'd10};

  // Operation codes.
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic [1:0]         stack_select;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
  } out_item_t;

  // What the memory side does with a classified request.
  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_ZERO,
    CMD_FAIL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [1:0] status;
  } pms_ctl_t;

endpackage

@@ src/pms_front.sv @@
// Request classifier: checks stack bounds, computes slot addresses and keeps the counts.
module pms_front #(
  parameter int DEPTH      = 64,
  parameter int STACKS     = 3,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  pms_pkg::in_item_t                        in_item,
  input  logic [STACKS-1:0][pms_pkg::SIZE_W-1:0]   sizes,
  output logic                                     q_push,
  input  logic                                     q_full,
  output pms_pkg::pms_ctl_t                        q_ctl,
  output logic [$clog2(DEPTH)-1:0]                 q_addr,
  output logic [DATA_WIDTH-1:0]                    q_data
);
  import pms_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = SIZE_W + $clog2(STACKS);
  localparam int CMP_W = (SW > AW + 1) ? SW : AW + 1;
  localparam int CPW   = (DATA_WIDTH < RES_W) ? DATA_WIDTH : RES_W;

  logic [SIZE_W-1:0] cnt_r   [STACKS];
  logic [SIZE_W-1:0] cnt_nxt [STACKS];

  logic              sel_ok;
  logic [SIZE_W-1:0] cur_cnt;
  logic [SIZE_W-1:0] cur_size;
  logic [SW-1:0]     start;
  logic [SW-1:0]     slot;
  logic [SW-1:0]     rd_slot;
  logic [CMP_W-1:0]  depth_c;
  logic              upd;
  logic              inc;
  logic              acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign q_push   = acc;
  assign depth_c  = CMP_W'(DEPTH);

  // Region start is the sum of the sizes of all lower-numbered stacks.
  always_comb begin
    sel_ok   = 1'b0;
    cur_cnt  = '0;
    cur_size = '0;
    start    = '0;
    for (int k = 0; k < STACKS; k++) begin
      if (int'(in_item.stack_select) == k) begin
        sel_ok   = 1'b1;
        cur_cnt  = cnt_r[k];
        cur_size = sizes[k];
      end
      if (int'(in_item.stack_select) > k) begin
        start = start + SW'(sizes[k]);
      end
    end
    slot    = start + SW'(cur_cnt);
    rd_slot = slot - SW'(1);
  end

  always_comb begin
    q_ctl.kind   = CMD_FAIL;
    q_ctl.status = ST_INVALID;
    q_addr       = '0;
    q_data       = DATA_WIDTH'(in_item.push_value[CPW-1:0]);
    upd          = 1'b0;
    inc          = 1'b0;
    if (sel_ok) begin
      case (in_item.operation)
        OP_PUSH: begin
          if (cur_cnt >= cur_size || CMP_W'(slot) >= depth_c) begin
            q_ctl.status = ST_FULL;
          end else begin
            q_ctl.kind   = CMD_WRITE;
            q_ctl.status = ST_OK;
            q_addr       = AW'(slot);
            upd          = 1'b1;
            inc          = 1'b1;
          end
        end
        OP_POP, OP_PEEK: begin
          if (cur_cnt == '0) begin
            q_ctl.status = ST_EMPTY;
          end else begin
            q_ctl.status = ST_OK;
            // A top slot past the memory end (after a region move) reads as zero.
            if (CMP_W'(rd_slot) >= depth_c) begin
              q_ctl.kind = CMD_ZERO;
            end else begin
              q_ctl.kind = CMD_READ;
              q_addr     = AW'(rd_slot);
            end
            upd = (in_item.operation == OP_POP);
          end
        end
        default: begin
          q_ctl.status = ST_INVALID;
        end
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < STACKS; k++) begin
      cnt_nxt[k] = cnt_r[k];
      if (acc && upd && int'(in_item.stack_select) == k) begin
        cnt_nxt[k] = inc ? cnt_r[k] + 1'b1 : cnt_r[k] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STACKS; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ src/pms_queue.sv @@
// Small FIFO of classified requests between the classifier and the memory side.
module pms_queue #(
  parameter int AW = 6,
  parameter int DW = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pms_pkg::pms_ctl_t ctl_in,
  input  logic [AW-1:0]     addr_in,
  input  logic [DW-1:0]     data_in,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output pms_pkg::pms_ctl_t ctl_out,
  output logic [AW-1:0]     addr_out,
  output logic [DW-1:0]     data_out
);
  import pms_pkg::*;

  localparam int PW   = $clog2(QDEPTH);
  localparam int CNTW = $clog2(QDEPTH + 1);

  pms_ctl_t      ctl_q  [QDEPTH];
  logic [AW-1:0] addr_q [QDEPTH];
  logic [DW-1:0] data_q [QDEPTH];

  logic [PW-1:0]   wp_r, wp_nxt;
  logic [PW-1:0]   rp_r, rp_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNTW'(QDEPTH));
  assign valid    = (cnt_r != '0);
  assign ctl_out  = ctl_q[rp_r];
  assign addr_out = addr_q[rp_r];
  assign data_out = data_q[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_q[wp_r]  <= ctl_in;
      addr_q[wp_r] <= addr_in;
      data_q[wp_r] <= data_in;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < CNTW'(QDEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("queue read while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == CNTW'($past(cnt_r) + 1'b1)))
    else $error("queue count did not follow a write");

endmodule

@@ src/pms_back.sv @@
// Memory side: owns the word memory, performs reads and writes in order and holds the result.
module pms_back #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  pms_pkg::pms_ctl_t          q_ctl,
  input  logic [$clog2(DEPTH)-1:0]   q_addr,
  input  logic [DATA_WIDTH-1:0]      q_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pms_pkg::out_item_t         out_item
);
  import pms_pkg::*;

  localparam int CPW = (DATA_WIDTH < RES_W) ? DATA_WIDTH : RES_W;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic                  s1_v_r, s1_v_nxt;
  pms_ctl_t              s1_ctl_r;
  logic [DATA_WIDTH-1:0] s1_data_r;
  logic [DATA_WIDTH-1:0] rdata_r;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r;
  logic [RES_W-1:0]      res;
  logic                  issue;
  logic                  s1_adv;

  assign s1_adv = s1_v_r && (!out_valid_r || out_ready);
  assign issue  = q_valid && (!s1_v_r || s1_adv);
  assign q_pop  = issue;

  assign s1_v_nxt      = issue || (s1_v_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (issue && q_ctl.kind == CMD_WRITE) begin
      mem[q_addr] <= q_data;
    end
    if (issue && q_ctl.kind == CMD_READ) begin
      rdata_r <= mem[q_addr];
    end
  end

  always_comb begin
    case (s1_ctl_r.kind)
      CMD_WRITE: res = RES_W'(s1_data_r[CPW-1:0]);
      CMD_READ:  res = RES_W'(rdata_r[CPW-1:0]);
      CMD_ZERO:  res = '0;
      default:   res = RES_W'({CPW{1'b1}});
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_ctl_r  <= q_ctl;
      s1_data_r <= q_data;
    end
    if (s1_adv) begin
      out_item_r.status     <= s1_ctl_r.status;
      out_item_r.read_value <= signed'(res);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_issue_lands: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> s1_v_r)
    else $error("issued request lost before the result stage");

  a_fail_status: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> ((s1_ctl_r.kind == CMD_FAIL) == (s1_ctl_r.status != ST_OK)))
    else $error("request kind and status disagree");

  a_result_status: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (out_valid_r && out_item_r.status == $past(s1_ctl_r.status)))
    else $error("result register did not take the request status");

endmodule

@@ src/partitioned_multi_stack.sv @@
// Top level of the partitioned multi-stack: configuration registers and the two halves.
//
//   channel   direction  transaction
//   in_*      input      one request: operation, stack_select, push_value
//   out_*     output     one result per request: status, read_value
//   p*        input      APB register access to the three stack sizes
//
// One transaction per cycle is sustained while out_ready is high; the single-port word
// memory, one access per request, sets that figure. The result is registered. Reset
// clears the element counts and loads sizes 20, 15 and 10; the word memory is not
// cleared. in_ready drops only when the two-entry request queue is full, and the queue
// and the result register let either side stall without stopping the other.
module partitioned_multi_stack #(
  parameter int DEPTH      = pms_pkg::PMS_DEPTH,
  parameter int STACKS     = pms_pkg::PMS_STACKS,
  parameter int DATA_WIDTH = pms_pkg::PMS_DATA_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pms_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pms_pkg::out_item_t          out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pms_pkg::CFG_AW-1:0]  paddr,
  input  logic [pms_pkg::CFG_DW-1:0]  pwdata,
  output logic [pms_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import pms_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [SIZE_W-1:0] size_r   [NUM_CFG];
  logic [SIZE_W-1:0] size_nxt [NUM_CFG];
  logic [1:0]        reg_idx;
  logic              cfg_wr;

  logic [STACKS-1:0][SIZE_W-1:0] sizes;

  logic          f_push;
  logic          q_full;
  pms_ctl_t      f_ctl;
  logic [AW-1:0] f_addr;
  logic [DATA_WIDTH-1:0] f_data;

  logic          q_valid;
  logic          q_pop;
  pms_ctl_t      q_ctl;
  logic [AW-1:0] q_addr;
  logic [DATA_WIDTH-1:0] q_data;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];

  always_comb begin
    size_nxt = size_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_FIRST_SIZE:  size_nxt[0] = pwdata[SIZE_W-1:0];
        REG_SECOND_SIZE: size_nxt[1] = pwdata[SIZE_W-1:0];
        REG_THIRD_SIZE:  size_nxt[2] = pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FIRST_SIZE:  prdata = CFG_DW'(size_r[0]);
      REG_SECOND_SIZE: prdata = CFG_DW'(size_r[1]);
      REG_THIRD_SIZE:  prdata = CFG_DW'(size_r[2]);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else begin
      size_r <= size_nxt;
    end
  end

  // Stacks beyond the configurable ones own an empty region.
  always_comb begin
    for (int k = 0; k < STACKS; k++) begin
      sizes[k] = (k < NUM_CFG) ? size_r[k] : '0;
    end
  end

  pms_front #(
    .DEPTH      (DEPTH),
    .STACKS     (STACKS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .sizes    (sizes),
    .q_push   (f_push),
    .q_full   (q_full),
    .q_ctl    (f_ctl),
    .q_addr   (f_addr),
    .q_data   (f_data)
  );

  pms_queue #(
    .AW (AW),
    .DW (DATA_WIDTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .ctl_in   (f_ctl),
    .addr_in  (f_addr),
    .data_in  (f_data),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .ctl_out  (q_ctl),
    .addr_out (q_addr),
    .data_out (q_data)
  );

  pms_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_ctl     (q_ctl),
    .q_addr    (q_addr),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
